// ===== rtl/tt_pkg.sv =====
// Shared types and constants for the text tokenizer.
package tt_pkg;

  typedef enum logic [3:0] {
    KIND_LPAREN  = 4'd0,
    KIND_RPAREN  = 4'd1,
    KIND_COMMA   = 4'd2,
    KIND_NEWLINE = 4'd3,
    KIND_END     = 4'd4,
    KIND_IDENT   = 4'd5,
    KIND_DEF     = 4'd6,
    KIND_SPACE   = 4'd7,
    KIND_STRING  = 4'd8,
    KIND_ERROR   = 4'd9
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_SPACE  = 2'd2,
    MODE_STRING = 2'd3
  } scan_mode_t;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  // One queue entry: all tokens caused by one byte. A single token sits in second.
  typedef struct packed {
    logic   dual;
    token_t first;
    token_t second;
  } entry_t;

  localparam logic [15:0] FIELD_MAX   = 16'hFFFF;
  localparam int          QUEUE_DEPTH = 4;

  localparam logic [2:0] KP_MISS = 3'd4;
  localparam logic [2:0] KP_FULL = 3'd3;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_E       = 8'h65;
  localparam logic [7:0] CH_F       = 8'h66;

endpackage

// ===== rtl/tt_byte_if.sv =====
// Byte stream channel into the tokenizer.
interface tt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== rtl/tt_token_if.sv =====
// Token stream channel out of the tokenizer.
interface tt_token_if;
  logic               valid;
  logic               ready;
  tt_pkg::token_kind_t token_kind;
  logic [15:0]        token_start;
  logic [15:0]        token_length;
  logic               last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== rtl/text_tokenizer.sv =====
// Top level of the streaming text tokenizer.
//
//   port    dir  word                                       handshake
//   text    in   text_byte                                  valid / ready
//   tokens  out  token_kind, token_start, token_length,     valid / ready
//                last_of_run
//
// One byte per cycle is taken while the entry queue has room; the front end
// classifies it in the same cycle. The back end sends one token per cycle from
// its output register while the receiver is ready; a byte that causes two tokens
// sends them one after the other. The four-entry queue absorbs such bursts and
// output stalls. Synchronous reset clears the scan state, queue pointers and out_valid.
module text_tokenizer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  tt_byte_if.sink    text,
  tt_token_if.source tokens
);
  import tt_pkg::*;

  logic   push, full, pop, empty;
  entry_t push_entry, head;

  tt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  tt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  tt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule

// ===== rtl/tt_front.sv =====
// Front end: accepts bytes, tracks the scan state and builds token entries.
module tt_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  tt_byte_if.sink       text,
  input  logic          queue_full,
  output logic          push,
  output tt_pkg::entry_t push_entry
);
  import tt_pkg::*;

  localparam int EXT_BITS = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  function automatic logic [15:0] sat_field(input logic [OFFSET_BITS-1:0] v);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    return (e > EXT_BITS'(FIELD_MAX)) ? FIELD_MAX : e[15:0];
  endfunction

  scan_mode_t             scan_mode, scan_mode_next;
  logic [OFFSET_BITS-1:0] run_start, run_start_next;
  logic [OFFSET_BITS-1:0] text_offset, text_offset_next;
  logic [2:0]             kw_progress, kw_progress_next;

  logic [7:0]             c;
  logic                   accept;
  logic                   letter, blank, handled;
  logic                   run_valid, own_valid;
  token_t                 run_tok, own_tok;
  logic [OFFSET_BITS-1:0] run_len;
  logic [7:0]             kw_char;

  assign c          = text.text_byte;
  assign text.ready = !queue_full && !rst;
  assign accept     = text.valid && text.ready;

  always_comb begin
    letter = c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
    blank  = c inside {CH_SPACE, CH_TAB};
    run_len = (text_offset >= run_start) ? (text_offset - run_start) : '0;
    case (kw_progress)
      3'd0:    kw_char = CH_D;
      3'd1:    kw_char = CH_E;
      default: kw_char = CH_F;
    endcase

    scan_mode_next   = scan_mode;
    run_start_next   = run_start;
    kw_progress_next = kw_progress;
    handled   = 1'b0;
    run_valid = 1'b0;
    own_valid = 1'b0;
    run_tok   = '{kind: KIND_IDENT, start: sat_field(run_start),
                  length: sat_field(run_len), last: 1'b0};
    own_tok   = '{kind: KIND_ERROR, start: sat_field(text_offset),
                  length: 16'd1, last: 1'b1};

    case (scan_mode)
      MODE_IDENT: begin
        if (letter) begin
          handled = 1'b1;
          kw_progress_next = (kw_progress < KP_FULL && c == kw_char) ?
                             kw_progress + 3'd1 : KP_MISS;
        end else begin
          run_valid      = 1'b1;
          run_tok.kind   = (kw_progress == KP_FULL) ? KIND_DEF : KIND_IDENT;
          scan_mode_next = MODE_IDLE;
        end
      end
      MODE_SPACE: begin
        if (blank) begin
          handled = 1'b1;
        end else begin
          run_valid      = 1'b1;
          run_tok.kind   = KIND_SPACE;
          scan_mode_next = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          run_valid      = 1'b1;
          run_tok.kind   = KIND_STRING;
          scan_mode_next = MODE_IDLE;
          handled        = 1'b1;
        end else if (c == CH_NUL) begin
          run_valid      = 1'b1;
          run_tok.kind   = KIND_ERROR;
          scan_mode_next = MODE_IDLE;
        end else begin
          handled = 1'b1;
        end
      end
      default: ;
    endcase

    if (!handled) begin
      case (c)
        CH_LPAREN:  begin own_valid = 1'b1; own_tok.kind = KIND_LPAREN;  end
        CH_RPAREN:  begin own_valid = 1'b1; own_tok.kind = KIND_RPAREN;  end
        CH_COMMA:   begin own_valid = 1'b1; own_tok.kind = KIND_COMMA;   end
        CH_NEWLINE: begin own_valid = 1'b1; own_tok.kind = KIND_NEWLINE; end
        CH_NUL: begin
          own_valid      = 1'b1;
          own_tok.kind   = KIND_END;
          own_tok.length = 16'd0;
        end
        default: begin
          if (letter) begin
            scan_mode_next   = MODE_IDENT;
            run_start_next   = text_offset;
            kw_progress_next = (c == CH_D) ? 3'd1 : KP_MISS;
          end else if (blank) begin
            scan_mode_next = MODE_SPACE;
            run_start_next = text_offset;
          end else if (c == CH_QUOTE) begin
            scan_mode_next = MODE_STRING;
            run_start_next = (text_offset != OFF_MAX) ?
                             text_offset + 1'b1 : OFF_MAX;
          end else begin
            own_valid = 1'b1;
          end
        end
      endcase
    end

    run_tok.last = !own_valid;

    if (c == CH_NUL) begin
      text_offset_next = '0;
      scan_mode_next   = MODE_IDLE;
      run_start_next   = '0;
      kw_progress_next = '0;
    end else begin
      text_offset_next = (text_offset != OFF_MAX) ? text_offset + 1'b1 : text_offset;
    end

    push              = accept && (run_valid || own_valid);
    push_entry.dual   = run_valid && own_valid;
    push_entry.first  = run_tok;
    push_entry.second = own_valid ? own_tok : run_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_IDLE;
      run_start   <= '0;
      text_offset <= '0;
      kw_progress <= '0;
    end else if (accept) begin
      scan_mode   <= scan_mode_next;
      run_start   <= run_start_next;
      text_offset <= text_offset_next;
      kw_progress <= kw_progress_next;
    end
  end

endmodule

// ===== rtl/tt_queue.sv =====
// Short entry queue between the front and back ends.
module tt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tt_pkg::entry_t push_entry,
  output logic           full,
  input  logic           pop,
  output tt_pkg::entry_t head,
  output logic           empty
);
  import tt_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  entry_t              slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tt_back.sv =====
// Back end: splits queue entries into single tokens behind an output register.
module tt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  tt_pkg::entry_t head,
  output logic           pop,
  tt_token_if.source     tokens
);
  import tt_pkg::*;

  logic   out_valid, out_valid_next;
  logic   sub, sub_next;
  token_t out_tok, out_tok_next;
  logic   load;

  always_comb begin
    load           = !out_valid || tokens.ready;
    out_valid_next = out_valid;
    sub_next       = sub;
    out_tok_next   = out_tok;
    pop            = 1'b0;
    if (load) begin
      out_valid_next = !empty;
      if (!empty) begin
        if (head.dual && !sub) begin
          out_tok_next = head.first;
          sub_next     = 1'b1;
        end else begin
          out_tok_next = head.second;
          sub_next     = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      sub       <= sub_next;
    end
  end

  always_ff @(posedge clk) begin
    out_tok <= out_tok_next;
  end

  assign tokens.valid        = out_valid;
  assign tokens.token_kind   = out_tok.kind;
  assign tokens.token_start  = out_tok.start;
  assign tokens.token_length = out_tok.length;
  assign tokens.last_of_run  = out_tok.last;

endmodule
